// File: hw/rtl/jsld_pkg.sv
// ----------------------------------------------------------------------------
// jsld_pkg
// Shared types and codes for the JSON string literal decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsld_pkg;

	localparam int LEN_W      = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_BODY = 3'd1;
	localparam logic [2:0] PH_ESC  = 3'd2;
	localparam logic [2:0] PH_HEX  = 3'd3;
	localparam logic [2:0] PH_UTF8 = 3'd4;

	localparam logic [1:0] KIND_UNIT  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] code_unit;
		logic [15:0] consumed_bytes;
		logic        last_of_run;
	} out_t;

	// up to two results produced by one byte
	typedef struct packed {
		logic [1:0] n;
		out_t       r0;
		out_t       r1;
	} res_pair_t;

endpackage

`default_nettype wire

// File: hw/rtl/jsld_step.sv
// ----------------------------------------------------------------------------
// jsld_step
// Decoder state and the per-byte update: quote, escape, \u hex and UTF-8.
// ----------------------------------------------------------------------------
`default_nettype none

module jsld_step import jsld_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire in_t       item,
	output res_pair_t      res
);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam logic [LEN_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [2:0]  ph;
		logic [1:0]  left;
		logic [20:0] pt;
		logic        has;
		out_t        r;
	} body_t;

	function automatic out_t mk(input logic [1:0] k, input logic [15:0] u,
			input logic [15:0] l);
		out_t o;
		o.kind           = k;
		o.code_unit      = u;
		o.consumed_bytes = l;
		o.last_of_run    = 1'b0;
		return o;
	endfunction

	// bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_fn(input logic [7:0] b);
		logic [4:0] h;
		h = '0;
		if (b >= 8'h30 && b <= 8'h39)
			h = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66)
			h = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46)
			h = {1'b1, 4'(b - 8'h37)};
		return h;
	endfunction

	function automatic body_t body_fn(input logic [7:0] b, input logic [LEN_W-1:0] cnt);
		body_t o;
		o = '0;
		o.ph = PH_BODY;
		if (b == CH_QUOTE) begin
			o.ph  = PH_IDLE;
			o.has = 1'b1;
			o.r   = mk(KIND_CLOSE, 16'h0,
				(cnt > LEN_W'(16'hFFFF)) ? 16'hFFFF : 16'(cnt));
		end else if (b == CH_BSL) begin
			o.ph = PH_ESC;
		end else if (b < 8'h80) begin
			o.has = 1'b1;
			o.r   = mk(KIND_UNIT, {8'h00, b}, 16'h0);
		end else if (b >= 8'hC2 && b <= 8'hDF) begin
			o.ph = PH_UTF8; o.left = 2'd1; o.pt = {16'h0, b[4:0]};
		end else if (b >= 8'hE0 && b <= 8'hEF) begin
			o.ph = PH_UTF8; o.left = 2'd2; o.pt = {17'h0, b[3:0]};
		end else if (b >= 8'hF0 && b <= 8'hF4) begin
			o.ph = PH_UTF8; o.left = 2'd3; o.pt = {18'h0, b[2:0]};
		end else begin
			o.has = 1'b1;
			o.r   = mk(KIND_UNIT, REPLACEMENT, 16'h0);
		end
		return o;
	endfunction

	logic [2:0]       phase_q, ph_d;
	logic [1:0]       hs_q, hs_d;
	logic [15:0]      hv_q, hv_d;
	logic [1:0]       ul_q, ul_d;
	logic [20:0]      up_q, up_d;
	logic [LEN_W-1:0] cnt_q, cnt_d;

	logic [7:0]  b;
	logic [1:0]  n;
	out_t        r0, r1;
	body_t       bb;
	logic        ok;
	logic [4:0]  hd;
	logic [20:0] pt_new, v;

	assign b = item.data_byte;

	always_comb begin
		ph_d   = phase_q;
		hs_d   = hs_q;
		hv_d   = hv_q;
		ul_d   = ul_q;
		up_d   = up_q;
		cnt_d  = cnt_q;
		n      = 2'd0;
		r0     = '0;
		r1     = '0;
		bb     = '0;
		hd     = hex_fn(b);
		pt_new = {up_q[14:0], b[5:0]};
		v      = pt_new - 21'h10000;
		ok     = (b[7:6] == 2'b10);
		if (ul_q == 2'd2 && up_q < 21'h10) begin
			if (up_q == 21'h0 && b < 8'hA0)
				ok = 1'b0;
			if (up_q == 21'hD && b >= 8'hA0)
				ok = 1'b0;
		end
		if (ul_q == 2'd3) begin
			if (up_q == 21'h0 && b < 8'h90)
				ok = 1'b0;
			if (up_q == 21'h4 && b >= 8'h90)
				ok = 1'b0;
		end

		if (phase_q == PH_IDLE) begin
			if (b == CH_QUOTE) begin
				cnt_d = LEN_W'(1);
				ph_d  = PH_BODY;
			end else begin
				n = 2'd1; r0 = mk(KIND_ERR, 16'h0, 16'h0);
				ph_d = PH_IDLE; hs_d = '0; hv_d = '0; ul_d = '0; up_d = '0;
			end
		end else begin
			if (cnt_q != CNT_MAX)
				cnt_d = cnt_q + LEN_W'(1);
			bb = body_fn(b, cnt_d);
			unique case (phase_q)
				PH_BODY: begin
					ph_d = bb.ph; ul_d = bb.left; up_d = bb.pt;
					if (bb.has) begin
						n = 2'd1; r0 = bb.r;
					end
				end
				PH_ESC: begin
					ph_d = PH_BODY;
					n    = 2'd1;
					unique case (b)
						CH_QUOTE: r0 = mk(KIND_UNIT, 16'h0022, 16'h0);
						CH_BSL:   r0 = mk(KIND_UNIT, 16'h005C, 16'h0);
						CH_SLASH: r0 = mk(KIND_UNIT, 16'h002F, 16'h0);
						CH_B:     r0 = mk(KIND_UNIT, 16'h0008, 16'h0);
						CH_F:     r0 = mk(KIND_UNIT, 16'h000C, 16'h0);
						CH_N:     r0 = mk(KIND_UNIT, 16'h000A, 16'h0);
						CH_R:     r0 = mk(KIND_UNIT, 16'h000D, 16'h0);
						CH_T:     r0 = mk(KIND_UNIT, 16'h0009, 16'h0);
						CH_U: begin
							n = 2'd0; ph_d = PH_HEX; hs_d = '0; hv_d = '0;
						end
						default: begin
							r0 = mk(KIND_ERR, 16'h0, 16'h0);
							ph_d = PH_IDLE; hs_d = '0; hv_d = '0; ul_d = '0; up_d = '0;
						end
					endcase
				end
				PH_HEX: begin
					if (!hd[4]) begin
						n = 2'd1; r0 = mk(KIND_ERR, 16'h0, 16'h0);
						ph_d = PH_IDLE; hs_d = '0; hv_d = '0; ul_d = '0; up_d = '0;
					end else if (hs_q == 2'd3) begin
						n = 2'd1; r0 = mk(KIND_UNIT, {hv_q[11:0], hd[3:0]}, 16'h0);
						hs_d = '0; hv_d = '0; ph_d = PH_BODY;
					end else begin
						hv_d = {hv_q[11:0], hd[3:0]};
						hs_d = hs_q + 2'd1;
					end
				end
				PH_UTF8: begin
					if (!ok || ul_q == 2'd0) begin
						r0 = mk(KIND_UNIT, REPLACEMENT, 16'h0);
						ph_d = bb.ph; ul_d = bb.left; up_d = bb.pt;
						if (bb.has) begin
							n = 2'd2; r1 = bb.r;
						end else begin
							n = 2'd1;
						end
					end else if (ul_q == 2'd1) begin
						ph_d = PH_BODY; ul_d = '0; up_d = '0;
						if (pt_new >= 21'h10000) begin
							n  = 2'd2;
							r0 = mk(KIND_UNIT, {6'b110110, v[19:10]}, 16'h0);
							r1 = mk(KIND_UNIT, {6'b110111, v[9:0]}, 16'h0);
						end else begin
							n  = 2'd1;
							r0 = mk(KIND_UNIT, pt_new[15:0], 16'h0);
						end
					end else begin
						up_d = pt_new;
						ul_d = ul_q - 2'd1;
					end
				end
				default: begin
					n = 2'd1; r0 = mk(KIND_ERR, 16'h0, 16'h0);
					ph_d = PH_IDLE; hs_d = '0; hv_d = '0; ul_d = '0; up_d = '0;
				end
			endcase
		end

		// buffer ran out with the literal still open
		if (item.buffer_end && ph_d != PH_IDLE) begin
			n = 2'd1; r0 = mk(KIND_ERR, 16'h0, 16'h0); r1 = '0;
			ph_d = PH_IDLE; hs_d = '0; hv_d = '0; ul_d = '0; up_d = '0;
		end

		r0.last_of_run = (n == 2'd1);
		r1.last_of_run = 1'b1;
		res.n  = n;
		res.r0 = r0;
		res.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hs_q    <= '0;
			hv_q    <= '0;
			ul_q    <= '0;
			up_q    <= '0;
			cnt_q   <= '0;
		end else if (fire) begin
			phase_q <= ph_d;
			hs_q    <= hs_d;
			hv_q    <= hv_d;
			ul_q    <= ul_d;
			up_q    <= up_d;
			cnt_q   <= cnt_d;
		end
	end

	a_pair_first_unit: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.n == 2'd2 |-> res.r0.kind == KIND_UNIT)
		else $error("first of two results is not a code unit");

	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.buffer_end |=> phase_q == PH_IDLE)
		else $error("decoder not idle after buffer end");

	a_hex_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HEX |-> hs_q == 2'd0)
		else $error("hex digit count set outside hex phase");

endmodule

`default_nettype wire

// File: hw/rtl/jsld_res_fifo.sv
// ----------------------------------------------------------------------------
// jsld_res_fifo
// Result queue: takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module jsld_res_fifo import jsld_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire res_pair_t wr,
	output out_t           rd,
	output logic           rd_valid,
	input  wire logic      rd_stall,
	output logic           room
);

	out_t                  mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wp_q, rp_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic [1:0]            push_n;
	logic                  pop;

	assign push_n   = wr_en ? wr.n : 2'd0;
	assign rd_valid = (cnt_q != '0);
	assign pop      = rd_valid && !rd_stall;
	assign rd       = mem[rp_q];
	assign room     = (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wp_q] <= wr.r0;
		if (push_n == 2'd2)
			mem[wp_q + FIFO_PTR_W'(1)] <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_PTR_W'(push_n);
			rp_q  <= rp_q + FIFO_PTR_W'(pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_pair_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2))
		else $error("result written without room");

	a_full_means_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> rd_valid)
		else $error("queue without room reports empty");

endmodule

`default_nettype wire

// File: hw/rtl/json_string_literal_decoder_core.sv
// ----------------------------------------------------------------------------
// json_string_literal_decoder_core
// JSON string literal decoder: one byte in, UTF-16 code units, close or error out.
//
//   channel  dir  handshake                  payload
//   item     in   item_valid / item_stall    in_t  (data_byte, buffer_end)
//   result   out  result_valid / result_stall out_t (kind, code_unit, ...)
//
// A byte is registered, decoded from that register and its results written
// into a four-entry result queue once the queue has room for two. One byte
// per clock sustained while the queue has room; a byte that yields a
// surrogate pair leaves through the single result port as two results.
// item_stall rises only when the queue has fewer than two free entries.
// Reset returns the decoder to waiting for an opening quote, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_literal_decoder_core import jsld_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_stall,
	input  wire in_t  item,
	output logic      result_valid,
	input  wire logic result_stall,
	output out_t      result
);

	logic      valid_s1;
	in_t       item_s1;
	logic      room;
	logic      fire;
	res_pair_t res;

	assign fire       = valid_s1 && room;
	assign item_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!item_stall)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	jsld_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	jsld_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (fire),
		.wr       (res),
		.rd       (result),
		.rd_valid (result_valid),
		.rd_stall (result_stall),
		.room     (room)
	);

endmodule

`default_nettype wire

// File: tb/json_string_literal_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// json_string_literal_decoder_core_tb
// Self-checking bench for the JSON string literal decoder.
//
// Bytes are sent over the item channel and each transfer is decoded by a
// scoreboard model, which queues the UTF-16 units, close reports and errors
// that the byte should cause. Every result transfer is compared field by
// field with the oldest queued entry. Stimulus is a short hand-written
// sequence, then random literals (escapes, \u codes, valid and broken UTF-8,
// bad escapes, bad hex, buffer ends mid-literal, noise between literals).
// Both sides idle at random, the receiver holds off long enough to back up
// the input, and the sender twice waits for every expected result to drain.
// ----------------------------------------------------------------------------

module json_string_literal_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jsld_pkg::*;

	localparam logic [7:0]  CH_QUOTE    = 8'h22;
	localparam logic [7:0]  CH_BSLASH   = 8'h5C;
	localparam logic [7:0]  CH_SLASH    = 8'h2F;
	localparam logic [7:0]  CH_B        = 8'h62;
	localparam logic [7:0]  CH_F        = 8'h66;
	localparam logic [7:0]  CH_N        = 8'h6E;
	localparam logic [7:0]  CH_R        = 8'h72;
	localparam logic [7:0]  CH_T        = 8'h74;
	localparam logic [7:0]  CH_U        = 8'h75;
	localparam logic [15:0] REPLACEMENT = 16'hFFFD;
	localparam int          QUIET_LIMIT = 2000;

	localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
		CH_B, CH_F, CH_N, CH_R, CH_T};

	class decode_scoreboard;
		logic [2:0]       phase;
		logic [1:0]       hex_seen;
		logic [15:0]      hex_val;
		logic [1:0]       utf_left;
		logic [20:0]      utf_pt;
		logic [LEN_W-1:0] count;
		out_t             expected_results[$];
		out_t             run[$];
		int               mismatches;
		int               n_units;
		int               n_high;
		int               n_closes;
		int               n_errors;
		int               longest;

		function new();
			go_idle();
			count = '0;
			mismatches = 0;
			n_units = 0;
			n_high = 0;
			n_closes = 0;
			n_errors = 0;
			longest = 0;
		endfunction

		static function int hex_value_of(logic [7:0] b);
			if (b >= "0" && b <= "9") return b - "0";
			if (b >= "a" && b <= "f") return b - "a" + 10;
			if (b >= "A" && b <= "F") return b - "A" + 10;
			return -1;
		endfunction

		function void add_result(logic [1:0] kind, logic [15:0] unit, logic [15:0] len);
			out_t r;
			if (run.size() < 2) begin
				r.kind = kind;
				r.code_unit = unit;
				r.consumed_bytes = len;
				r.last_of_run = 1'b0;
				run.push_back(r);
			end
		endfunction

		function void go_idle();
			phase = PH_IDLE;
			hex_seen = '0;
			hex_val = '0;
			utf_left = '0;
			utf_pt = '0;
		endfunction

		function void raise_error();
			add_result(KIND_ERR, '0, '0);
			go_idle();
		endfunction

		function void body_byte(logic [7:0] b);
			if (b == CH_QUOTE) begin
				add_result(KIND_CLOSE, '0,
					(count > LEN_W'(16'hFFFF)) ? 16'hFFFF : 16'(count));
				go_idle();
			end else if (b == CH_BSLASH) begin
				phase = PH_ESC;
			end else if (b < 8'h80) begin
				add_result(KIND_UNIT, {8'h00, b}, '0);
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				phase = PH_UTF8;
				utf_left = 2'd1;
				utf_pt = {16'd0, b[4:0]};
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				phase = PH_UTF8;
				utf_left = 2'd2;
				utf_pt = {17'd0, b[3:0]};
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				phase = PH_UTF8;
				utf_left = 2'd3;
				utf_pt = {18'd0, b[2:0]};
			end else begin
				add_result(KIND_UNIT, REPLACEMENT, '0);
			end
		endfunction

		function void utf8_byte(logic [7:0] b);
			bit          ok;
			logic [20:0] v;
			ok = (b >= 8'h80 && b <= 8'hBF);
			if (ok && utf_left == 2'd2 && utf_pt < 21'h10) begin
				if (utf_pt == 21'h0 && b < 8'hA0) ok = 0;
				if (utf_pt == 21'hD && b >= 8'hA0) ok = 0;
			end
			if (ok && utf_left == 2'd3) begin
				if (utf_pt == 21'h0 && b < 8'h90) ok = 0;
				if (utf_pt == 21'h4 && b >= 8'h90) ok = 0;
			end
			if (!ok || utf_left == 2'd0) begin
				add_result(KIND_UNIT, REPLACEMENT, '0);
				phase = PH_BODY;
				utf_left = '0;
				utf_pt = '0;
				body_byte(b);
				return;
			end
			utf_pt = {utf_pt[14:0], b[5:0]};
			utf_left = utf_left - 2'd1;
			if (utf_left == 2'd0) begin
				phase = PH_BODY;
				if (utf_pt >= 21'h10000) begin
					v = utf_pt - 21'h10000;
					add_result(KIND_UNIT, {6'b110110, v[19:10]}, '0);
					add_result(KIND_UNIT, {6'b110111, v[9:0]}, '0);
				end else begin
					add_result(KIND_UNIT, utf_pt[15:0], '0);
				end
				utf_pt = '0;
			end
		endfunction

		function void take_byte(in_t it);
			logic [7:0] b;
			int         d;
			b = it.data_byte;
			run.delete();
			if (phase == PH_IDLE) begin
				if (b == CH_QUOTE) begin
					count = LEN_W'(1);
					phase = PH_BODY;
				end else begin
					raise_error();
				end
			end else begin
				if (count != '1) count = count + LEN_W'(1);
				case (phase)
					PH_BODY: body_byte(b);
					PH_ESC: begin
						phase = PH_BODY;
						case (b)
							CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(KIND_UNIT, {8'h00, b}, '0);
							CH_B: add_result(KIND_UNIT, 16'h0008, '0);
							CH_F: add_result(KIND_UNIT, 16'h000C, '0);
							CH_N: add_result(KIND_UNIT, 16'h000A, '0);
							CH_R: add_result(KIND_UNIT, 16'h000D, '0);
							CH_T: add_result(KIND_UNIT, 16'h0009, '0);
							CH_U: begin
								phase = PH_HEX;
								hex_seen = '0;
								hex_val = '0;
							end
							default: raise_error();
						endcase
					end
					PH_HEX: begin
						d = hex_value_of(b);
						if (d < 0) begin
							raise_error();
						end else begin
							hex_val = {hex_val[11:0], d[3:0]};
							if (hex_seen == 2'd3) begin
								add_result(KIND_UNIT, hex_val, '0);
								hex_seen = '0;
								hex_val = '0;
								phase = PH_BODY;
							end else begin
								hex_seen = hex_seen + 2'd1;
							end
						end
					end
					PH_UTF8: utf8_byte(b);
					default: raise_error();
				endcase
			end
			if (it.buffer_end && phase != PH_IDLE) begin
				run.delete();
				raise_error();
			end
			foreach (run[i]) begin
				run[i].last_of_run = (i == run.size() - 1);
				expected_results.push_back(run[i]);
			end
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			if (mismatches < 40)
				$display("mismatch %s: got %0h, expected %0h", what, got, want);
			mismatches++;
		endtask

		task check_result(out_t got);
			out_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", got, '0);
				return;
			end
			want = expected_results.pop_front();
			if (got.kind !== want.kind)
				report_mismatch("kind", got.kind, want.kind);
			if (got.code_unit !== want.code_unit)
				report_mismatch("code_unit", got.code_unit, want.code_unit);
			if (got.consumed_bytes !== want.consumed_bytes)
				report_mismatch("consumed_bytes", got.consumed_bytes, want.consumed_bytes);
			if (got.last_of_run !== want.last_of_run)
				report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
			case (want.kind)
				KIND_UNIT: begin
					n_units++;
					if (want.code_unit[15:10] == 6'b110110) n_high++;
				end
				KIND_CLOSE: begin
					n_closes++;
					if (want.consumed_bytes > longest) longest = want.consumed_bytes;
				end
				default: n_errors++;
			endcase
		endtask

		task flush_leftover();
			while (expected_results.size() != 0)
				report_mismatch("result never arrived", '0, expected_results.pop_front());
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_t  item;
	logic result_valid;
	logic result_stall;
	out_t result;

	decode_scoreboard sb = new();
	in_t text_q[$];
	int  sent;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_left;
	int  quiet;

	json_string_literal_decoder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) sb.take_byte(item);
			if (result_valid && !result_stall) sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet = quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no transfer in %0d cycles", quiet);
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic void put(logic [7:0] b, bit be = 1'b0);
		in_t it;
		it.data_byte = b;
		it.buffer_end = be;
		text_q.push_back(it);
	endfunction

	function automatic logic [7:0] printable();
		logic [7:0] b;
		do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [7:0] hex_char(int d);
		if (d < 10) return 8'(8'h30 + d);
		return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 10);
	endfunction

	function automatic logic [7:0] cont();
		return 8'(8'h80 | $urandom_range(0, 63));
	endfunction

	function automatic int unsigned random_scalar();
		int unsigned edges [8] = '{32'h80, 32'h7FF, 32'h800, 32'hD7FF, 32'hE000,
			32'hFFFF, 32'h10000, 32'h10FFFF};
		int unsigned cp;
		if ($urandom_range(99) < 20) return edges[$urandom_range(0, 7)];
		case ($urandom_range(0, 2))
			0: cp = $urandom_range(32'h80, 32'h7FF);
			1: do cp = $urandom_range(32'h800, 32'hFFFF); while (cp >= 32'hD800 && cp <= 32'hDFFF);
			default: cp = $urandom_range(32'h10000, 32'h10FFFF);
		endcase
		return cp;
	endfunction

	function automatic void put_utf8(int unsigned cp);
		if (cp < 32'h800) begin
			put(8'(8'hC0 | (cp >> 6)));
		end else if (cp < 32'h10000) begin
			put(8'(8'hE0 | (cp >> 12)));
			put(8'(8'h80 | ((cp >> 6) & 8'h3F)));
		end else begin
			put(8'(8'hF0 | (cp >> 18)));
			put(8'(8'h80 | ((cp >> 12) & 8'h3F)));
			put(8'(8'h80 | ((cp >> 6) & 8'h3F)));
		end
		put(8'(8'h80 | (cp & 8'h3F)));
	endfunction

	function automatic void put_malformed();
		int k;
		case ($urandom_range(0, 7))
			0: put(cont());
			1: begin
				k = $urandom_range(0, 12);
				put(8'(k < 2 ? 8'hC0 + k : 8'hF5 + (k - 2)));
			end
			2: begin
				put(8'hE0); put(8'($urandom_range(8'h80, 8'h9F))); put(cont());
			end
			3: begin
				put(8'hED); put(8'($urandom_range(8'hA0, 8'hBF))); put(cont());
			end
			4: begin
				put(8'hF4); put(8'($urandom_range(8'h90, 8'hBF))); put(cont()); put(cont());
			end
			5: begin
				put(8'hF0); put(8'($urandom_range(8'h80, 8'h8F))); put(cont()); put(cont());
			end
			6: begin
				put(8'($urandom_range(8'hC2, 8'hF4)));
				if ($urandom_range(0, 1)) put(cont());
				put(printable());
			end
			default: begin
				put(8'($urandom_range(8'h80, 8'hFF))); put(8'($urandom_range(8'h80, 8'hFF)));
			end
		endcase
	endfunction

	function automatic void build_literal();
		int         tokens;
		int         pick;
		bit         stop;
		logic [7:0] b;
		if ($urandom_range(99) < 6)
			repeat ($urandom_range(1, 3))
				put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		put(CH_QUOTE);
		tokens = $urandom_range(0, 12);
		stop = 0;
		for (int i = 0; i < tokens && !stop; i++) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				put(printable());
			end else if (pick < 40) begin
				put(8'($urandom_range(0, 8'h1F)));
			end else if (pick < 52) begin
				put(CH_BSLASH);
				put(ESC_LETTERS[$urandom_range(0, 7)]);
			end else if (pick < 60) begin
				put(CH_BSLASH);
				put(CH_U);
				repeat (4) put(hex_char($urandom_range(0, 15)));
			end else if (pick < 80) begin
				put_utf8(random_scalar());
			end else if (pick < 91) begin
				put_malformed();
			end else if (pick < 94) begin
				put(CH_BSLASH);
				do b = 8'($urandom_range(0, 255));
				while (b == CH_U || b inside {ESC_LETTERS});
				put(b);
				stop = 1;
			end else if (pick < 97) begin
				put(CH_BSLASH);
				put(CH_U);
				repeat ($urandom_range(0, 3)) put(hex_char($urandom_range(0, 15)));
				do b = 8'($urandom_range(0, 255));
				while (decode_scoreboard::hex_value_of(b) >= 0);
				put(b);
				stop = 1;
			end else begin
				put(8'($urandom_range(0, 255)), 1'b1);
				stop = 1;
			end
		end
		if (!stop) put(CH_QUOTE, $urandom_range(99) < 25);
	endfunction

	task automatic send_byte(in_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i]) send_byte(text_q[i]);
		text_q.delete();
	endtask

	task automatic drain_expected();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic run_random(int target, bit pressure);
		int start;
		bit held;
		bit paused;
		start = sent;
		held = 0;
		paused = 0;
		while (sent - start < target) begin
			if (pressure && !held && sent - start > target / 3) begin
				hold_left = 90;
				held = 1;
			end
			if (pressure && !paused && sent - start > 2 * target / 3) begin
				drain_expected();
				paused = 1;
			end
			build_literal();
			send_text();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		quiet = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no opening quote, escape, \u surrogate, control byte, 4-byte scalar,
		// bad lead, close at buffer end, bad escape, bad hex, buffer end inside
		put(8'h00); put(8'hFF);
		put(CH_QUOTE); put(CH_BSLASH); put(CH_N);
		put(CH_BSLASH); put(CH_U); put("D"); put("8"); put("0"); put("f");
		put(8'h01); put(8'hF0); put(8'h9F); put(8'h98); put(8'h80); put(8'hFF);
		put(CH_QUOTE, 1'b1);
		put(CH_QUOTE); put(CH_BSLASH); put("q");
		put(CH_QUOTE); put(CH_BSLASH); put(CH_U); put("g");
		put(CH_QUOTE); put("a", 1'b1);
		send_text();

		send_idle_pct = 7;
		recv_idle_pct = 50;
		run_random(270, 1'b1);

		send_idle_pct = 50;
		recv_idle_pct = 7;
		run_random(270, 1'b1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(260, 1'b0);

		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		sb.flush_leftover();

		$display("run: %0d bytes in, %0d code units (%0d high surrogates), %0d closes, %0d errors",
			sent, sb.n_units, sb.n_high, sb.n_closes, sb.n_errors);
		$display("run: longest literal %0d bytes, with receiver hold-off and a full drain",
			sb.longest);
		if (sb.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/jsld_pkg.sv
hw/rtl/jsld_step.sv
hw/rtl/jsld_res_fifo.sv
hw/rtl/json_string_literal_decoder_core.sv
tb/json_string_literal_decoder_core_tb.sv
